[rtl/lhhe_pkg.sv]
// Package for the link handshake and heartbeat engine.
// Holds the item structs, operation, action, error and link-state codes, and opcodes.
// No dependencies.
package lhhe_pkg;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_DATAGRAM = 2'd1,
		OP_APP_SEND = 2'd2,
		OP_LINK_LOST = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_SEND    = 2'd1,
		ACT_DELIVER = 2'd2,
		ACT_ERROR   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ERR_NONE         = 3'd0,
		ERR_NO_RESPONSE  = 3'd1,
		ERR_WRONG_RESP   = 3'd2,
		ERR_HB_TIMEOUT   = 3'd3,
		ERR_LINK_LOST    = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		LINK_DOWN        = 2'd0,
		LINK_HANDSHAKING = 2'd1,
		LINK_UP          = 2'd2
	} link_t;

	typedef enum logic [2:0] {
		REG_RESPONSE_TIMEOUT   = 3'd0,
		REG_RETRY_LIMIT        = 3'd1,
		REG_HEARTBEAT_INTERVAL = 3'd2,
		REG_HEARTBEAT_TIMEOUT  = 3'd3,
		REG_HEADER_VALUE       = 3'd4
	} reg_idx_t;

	localparam logic [7:0] OPC_HANDSHAKE1 = 8'h01;
	localparam logic [7:0] OPC_HANDSHAKE2 = 8'h02;
	localparam logic [7:0] OPC_HEARTBEAT  = 8'h03;
	localparam logic [7:0] OPC_PING       = 8'h04;
	localparam logic [7:0] OPC_PONG       = 8'h05;
	localparam logic [7:0] NET_OPC_LIMIT  = 8'h10;

	localparam logic [7:0] MIN_DGRAM_LEN  = 8'd8;

	localparam logic [15:0] RESPONSE_TIMEOUT_RST   = 16'd1000;
	localparam logic [3:0]  RETRY_LIMIT_RST        = 4'd3;
	localparam logic [15:0] HEARTBEAT_INTERVAL_RST = 16'd1000;
	localparam logic [15:0] HEARTBEAT_TIMEOUT_RST  = 16'd5000;
	localparam logic [7:0]  HEADER_VALUE_RST       = 8'd0;

	typedef struct packed {
		op_t         operation;
		logic [31:0] time_now;
		logic [7:0]  dgram_length;
		logic [7:0]  header_byte;
		logic [7:0]  opcode;
		logic [31:0] rx_sequence;
	} cmd_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  out_opcode;
		logic [31:0] tx_sequence;
		err_t        error_code;
		link_t       link_state;
		logic        last;
	} rsp_t;

endpackage

[rtl/link_handshake_heartbeat_engine_core.sv]
// Top level of the link handshake and heartbeat engine.
// Depends on lhhe_pkg for the item structs and all codes.
//
//  channel | direction | payload | handshake
//  cmd     | in        | cmd_t   | cmd_valid / cmd_stall
//  rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//  cfg     | in        | 16 bits | cfg_we, cfg_index (write only)
//
// An item is registered on acceptance into the input stage; from there its one or
// two results are written into a four-entry result queue once the queue has room.
// One item is taken per cycle as long as the queue has room for two more results.
// Reset clears link state, counters, timestamps, the queue and the registers to
// their defaults. A stall on rsp backs up through the queue into cmd_stall.
module link_handshake_heartbeat_engine_core
	import lhhe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	// Configuration registers.
	logic [15:0] response_timeout_q;
	logic [3:0]  retry_limit_q;
	logic [15:0] heartbeat_interval_q;
	logic [15:0] heartbeat_timeout_q;
	logic [7:0]  header_value_q;

	// Link state.
	link_t       conn_state_q;
	logic [3:0]  try_count_q;
	logic [31:0] recv_seq_last_q;
	logic [31:0] send_seq_next_q;
	logic [31:0] hs_sent_time_q;
	logic [31:0] hb_sent_time_q;
	logic [31:0] hb_recv_time_q;

	// Input stage.
	logic        valid_s1;
	cmd_t        cmd_s1;

	// Result queue.
	rsp_t        fifo_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  count_q;

	logic        pop;
	logic        adv;
	logic [2:0]  count_after_pop;

	// Combinational results of the item in the input stage.
	rsp_t        res0;
	rsp_t        res1;
	logic        two_res;
	link_t       conn_state_d;
	logic [3:0]  try_count_d;
	logic [31:0] recv_seq_last_d;
	logic [31:0] send_seq_next_d;
	logic [31:0] hs_sent_time_d;
	logic [31:0] hb_sent_time_d;
	logic [31:0] hb_recv_time_d;

	logic        hs_expired;
	logic        hb_send_due;
	logic        hb_expired;
	logic        dgram_ok;

	always_comb begin
		hs_expired  = (cmd_s1.time_now - hs_sent_time_q) > {16'd0, response_timeout_q};
		hb_send_due = (cmd_s1.time_now - hb_sent_time_q) > {16'd0, heartbeat_interval_q};
		hb_expired  = (cmd_s1.time_now - hb_recv_time_q) > {16'd0, heartbeat_timeout_q};
		dgram_ok    = (cmd_s1.dgram_length >= MIN_DGRAM_LEN)
			&& (cmd_s1.header_byte == header_value_q)
			&& (cmd_s1.rx_sequence > recv_seq_last_q);
	end

	always_comb begin
		conn_state_d    = conn_state_q;
		try_count_d     = try_count_q;
		recv_seq_last_d = recv_seq_last_q;
		send_seq_next_d = send_seq_next_q;
		hs_sent_time_d  = hs_sent_time_q;
		hb_sent_time_d  = hb_sent_time_q;
		hb_recv_time_d  = hb_recv_time_q;
		two_res         = 1'b0;

		res0 = '{action: ACT_NONE, out_opcode: 8'd0, tx_sequence: 32'd0,
			error_code: ERR_NONE, link_state: conn_state_q, last: 1'b1};
		res1 = '{action: ACT_ERROR, out_opcode: 8'd0, tx_sequence: 32'd0,
			error_code: ERR_HB_TIMEOUT, link_state: LINK_DOWN, last: 1'b1};

		case (cmd_s1.operation)
			OP_TICK: begin
				case (conn_state_q)
					LINK_HANDSHAKING: begin
						if (hs_expired) begin
							if (try_count_q < retry_limit_q) begin
								try_count_d     = try_count_q + 4'd1;
								send_seq_next_d = send_seq_next_q + 32'd1;
								hs_sent_time_d  = cmd_s1.time_now;
								res0.action      = ACT_SEND;
								res0.out_opcode  = OPC_HANDSHAKE1;
								res0.tx_sequence = send_seq_next_q;
							end else begin
								conn_state_d    = LINK_DOWN;
								res0.action     = ACT_ERROR;
								res0.error_code = ERR_NO_RESPONSE;
								res0.link_state = LINK_DOWN;
							end
						end
					end
					LINK_UP: begin
						if (hb_send_due) begin
							send_seq_next_d  = send_seq_next_q + 32'd1;
							hb_sent_time_d   = cmd_s1.time_now;
							res0.action      = ACT_SEND;
							res0.out_opcode  = OPC_HEARTBEAT;
							res0.tx_sequence = send_seq_next_q;
						end
						if (hb_expired) begin
							// The timeout wipes sequences and timestamps.
							conn_state_d    = LINK_DOWN;
							recv_seq_last_d = 32'd0;
							send_seq_next_d = 32'd0;
							hs_sent_time_d  = 32'd0;
							hb_sent_time_d  = 32'd0;
							hb_recv_time_d  = 32'd0;
							if (hb_send_due) begin
								res0.last = 1'b0;
								two_res   = 1'b1;
							end else begin
								res0 = res1;
							end
						end
					end
					default: begin
						conn_state_d     = LINK_HANDSHAKING;
						try_count_d      = 4'd1;
						send_seq_next_d  = send_seq_next_q + 32'd1;
						hs_sent_time_d   = cmd_s1.time_now;
						res0.action      = ACT_SEND;
						res0.out_opcode  = OPC_HANDSHAKE1;
						res0.tx_sequence = send_seq_next_q;
						res0.link_state  = LINK_HANDSHAKING;
					end
				endcase
			end
			OP_DATAGRAM: begin
				if ((conn_state_q == LINK_HANDSHAKING || conn_state_q == LINK_UP)
					&& dgram_ok) begin
					recv_seq_last_d = cmd_s1.rx_sequence;
					if (conn_state_q == LINK_HANDSHAKING) begin
						if (cmd_s1.opcode == OPC_HANDSHAKE2) begin
							conn_state_d     = LINK_UP;
							send_seq_next_d  = send_seq_next_q + 32'd1;
							hb_sent_time_d   = cmd_s1.time_now;
							hb_recv_time_d   = cmd_s1.time_now;
							res0.action      = ACT_SEND;
							res0.out_opcode  = OPC_HEARTBEAT;
							res0.tx_sequence = send_seq_next_q;
							res0.link_state  = LINK_UP;
						end else begin
							conn_state_d    = LINK_DOWN;
							res0.action     = ACT_ERROR;
							res0.error_code = ERR_WRONG_RESP;
							res0.link_state = LINK_DOWN;
						end
					end else if (cmd_s1.opcode < NET_OPC_LIMIT) begin
						if (cmd_s1.opcode == OPC_HEARTBEAT) begin
							hb_recv_time_d = cmd_s1.time_now;
						end else if (cmd_s1.opcode == OPC_PING) begin
							send_seq_next_d  = send_seq_next_q + 32'd1;
							res0.action      = ACT_SEND;
							res0.out_opcode  = OPC_PONG;
							res0.tx_sequence = send_seq_next_q;
						end
					end else begin
						res0.action     = ACT_DELIVER;
						res0.out_opcode = cmd_s1.opcode;
					end
				end
			end
			OP_APP_SEND: begin
				send_seq_next_d  = send_seq_next_q + 32'd1;
				res0.action      = ACT_SEND;
				res0.out_opcode  = cmd_s1.opcode;
				res0.tx_sequence = send_seq_next_q;
			end
			default: begin
				conn_state_d    = LINK_DOWN;
				res0.action     = ACT_ERROR;
				res0.error_code = ERR_LINK_LOST;
				res0.link_state = LINK_DOWN;
			end
		endcase
	end

	// The input stage moves on only when the queue can take two results.
	assign pop             = rsp_valid && !rsp_stall;
	assign count_after_pop = count_q - {2'd0, pop};
	assign adv             = valid_s1 && (count_after_pop <= 3'd2);
	assign cmd_stall       = valid_s1 && !adv;
	assign rsp_valid       = (count_q != 3'd0);
	assign rsp             = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fifo_q[wr_ptr_q] <= res0;
			if (two_res) begin
				fifo_q[wr_ptr_q + 2'd1] <= res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (adv) begin
				wr_ptr_q <= wr_ptr_q + (two_res ? 2'd2 : 2'd1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_after_pop + (adv ? (two_res ? 3'd2 : 3'd1) : 3'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_state_q    <= LINK_DOWN;
			try_count_q     <= 4'd0;
			recv_seq_last_q <= 32'd0;
			send_seq_next_q <= 32'd0;
			hs_sent_time_q  <= 32'd0;
			hb_sent_time_q  <= 32'd0;
			hb_recv_time_q  <= 32'd0;
		end else if (adv) begin
			conn_state_q    <= conn_state_d;
			try_count_q     <= try_count_d;
			recv_seq_last_q <= recv_seq_last_d;
			send_seq_next_q <= send_seq_next_d;
			hs_sent_time_q  <= hs_sent_time_d;
			hb_sent_time_q  <= hb_sent_time_d;
			hb_recv_time_q  <= hb_recv_time_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			response_timeout_q   <= RESPONSE_TIMEOUT_RST;
			retry_limit_q        <= RETRY_LIMIT_RST;
			heartbeat_interval_q <= HEARTBEAT_INTERVAL_RST;
			heartbeat_timeout_q  <= HEARTBEAT_TIMEOUT_RST;
			header_value_q       <= HEADER_VALUE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESPONSE_TIMEOUT:   response_timeout_q   <= cfg_wdata;
				REG_RETRY_LIMIT:        retry_limit_q        <= cfg_wdata[3:0];
				REG_HEARTBEAT_INTERVAL: heartbeat_interval_q <= cfg_wdata;
				REG_HEARTBEAT_TIMEOUT:  heartbeat_timeout_q  <= cfg_wdata;
				REG_HEADER_VALUE:       header_value_q       <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

endmodule

[dv/tb_link_handshake_heartbeat_engine_core.sv]
// Self-checking testbench for link_handshake_heartbeat_engine_core.
// A tracker class predicts every result of the link engine and checks them in order.
// Depends on lhhe_pkg and the core RTL only.
module tb_link_handshake_heartbeat_engine_core;
	import lhhe_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	class link_tracker;
		logic [15:0] resp_to;
		logic [3:0]  retry_lim;
		logic [15:0] hb_int;
		logic [15:0] hb_to;
		logic [7:0]  hdr_val;
		link_t       st;
		logic [3:0]  tries;
		logic [31:0] rx_seq_hi;
		logic [31:0] tx_seq_nx;
		logic [31:0] hs_time;
		logic [31:0] hb_tx_time;
		logic [31:0] hb_rx_time;
		rsp_t        due_results[$];
		rsp_t        batch[$];
		int          errors;

		function new();
			resp_to   = RESPONSE_TIMEOUT_RST;
			retry_lim = RETRY_LIMIT_RST;
			hb_int    = HEARTBEAT_INTERVAL_RST;
			hb_to     = HEARTBEAT_TIMEOUT_RST;
			hdr_val   = HEADER_VALUE_RST;
			st        = LINK_DOWN;
			tries     = 4'd0;
			errors    = 0;
			clear_link_stats();
		endfunction

		function void clear_link_stats();
			rx_seq_hi  = 32'd0;
			tx_seq_nx  = 32'd0;
			hs_time    = 32'd0;
			hb_tx_time = 32'd0;
			hb_rx_time = 32'd0;
		endfunction

		function void note_cfg(reg_idx_t idx, logic [15:0] val);
			case (idx)
				REG_RESPONSE_TIMEOUT:   resp_to = val;
				REG_RETRY_LIMIT:        retry_lim = val[3:0];
				REG_HEARTBEAT_INTERVAL: hb_int = val;
				REG_HEARTBEAT_TIMEOUT:  hb_to = val;
				REG_HEADER_VALUE:       hdr_val = val[7:0];
				default: ;
			endcase
		endfunction

		// The deadline counts as passed only when strictly exceeded, modulo 2^32.
		function bit past_limit(logic [31:0] now, logic [31:0] start, logic [15:0] lim);
			logic [31:0] span;
			span = now - start;
			return span > {16'd0, lim};
		endfunction

		function void add(action_t act, logic [7:0] opc, logic [31:0] seq, err_t err);
			rsp_t r;
			r.action      = act;
			r.out_opcode  = opc;
			r.tx_sequence = seq;
			r.error_code  = err;
			r.link_state  = st;
			r.last        = 1'b0;
			batch.push_back(r);
		endfunction

		function void add_send(logic [7:0] opc);
			add(ACT_SEND, opc, tx_seq_nx, ERR_NONE);
			tx_seq_nx = tx_seq_nx + 32'd1;
		endfunction

		function void run_timers(logic [31:0] now);
			case (st)
				LINK_HANDSHAKING: begin
					if (past_limit(now, hs_time, resp_to)) begin
						if (tries < retry_lim) begin
							tries = tries + 4'd1;
							add_send(OPC_HANDSHAKE1);
							hs_time = now;
						end else begin
							st = LINK_DOWN;
							add(ACT_ERROR, 8'd0, 32'd0, ERR_NO_RESPONSE);
						end
					end
				end
				LINK_UP: begin
					if (past_limit(now, hb_tx_time, hb_int)) begin
						add_send(OPC_HEARTBEAT);
						hb_tx_time = now;
					end
					if (past_limit(now, hb_rx_time, hb_to)) begin
						clear_link_stats();
						st = LINK_DOWN;
						add(ACT_ERROR, 8'd0, 32'd0, ERR_HB_TIMEOUT);
					end
				end
				default: begin
					st = LINK_HANDSHAKING;
					tries = 4'd1;
					add_send(OPC_HANDSHAKE1);
					hs_time = now;
				end
			endcase
		endfunction

		function void take_datagram(cmd_t c);
			if (st != LINK_HANDSHAKING && st != LINK_UP)
				return;
			if (c.dgram_length < MIN_DGRAM_LEN || c.header_byte != hdr_val ||
			    c.rx_sequence <= rx_seq_hi)
				return;
			rx_seq_hi = c.rx_sequence;
			if (st == LINK_HANDSHAKING) begin
				if (c.opcode == OPC_HANDSHAKE2) begin
					st = LINK_UP;
					add_send(OPC_HEARTBEAT);
					hb_tx_time = c.time_now;
					hb_rx_time = c.time_now;
				end else begin
					st = LINK_DOWN;
					add(ACT_ERROR, 8'd0, 32'd0, ERR_WRONG_RESP);
				end
				return;
			end
			if (c.opcode < NET_OPC_LIMIT) begin
				if (c.opcode == OPC_HEARTBEAT)
					hb_rx_time = c.time_now;
				else if (c.opcode == OPC_PING)
					add_send(OPC_PONG);
			end else begin
				add(ACT_DELIVER, c.opcode, 32'd0, ERR_NONE);
			end
		endfunction

		function void note_event(cmd_t c);
			rsp_t final_one;
			batch.delete();
			case (c.operation)
				OP_TICK:     run_timers(c.time_now);
				OP_DATAGRAM: take_datagram(c);
				OP_APP_SEND: add_send(c.opcode);
				default: begin
					st = LINK_DOWN;
					add(ACT_ERROR, 8'd0, 32'd0, ERR_LINK_LOST);
				end
			endcase
			if (batch.size() == 0)
				add(ACT_NONE, 8'd0, 32'd0, ERR_NONE);
			final_one = batch.pop_back();
			final_one.last = 1'b1;
			batch.push_back(final_one);
			foreach (batch[i])
				due_results.push_back(batch[i]);
		endfunction

		function string show(rsp_t r);
			return $sformatf("action %0d opcode %02h seq %08h error %0d link %0d last %0d",
				r.action, r.out_opcode, r.tx_sequence, r.error_code, r.link_state, r.last);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch %0d: %s", errors, msg);
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			if (due_results.size() == 0) begin
				report({"result with none expected: ", show(got)});
				return;
			end
			want = due_results.pop_front();
			if (got.action !== want.action || got.out_opcode !== want.out_opcode ||
			    got.tx_sequence !== want.tx_sequence || got.error_code !== want.error_code ||
			    got.link_state !== want.link_state || got.last !== want.last)
				report({"got ", show(got), " want ", show(want)});
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	cmd_t        cmd;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_we;
	reg_idx_t    cfg_index;
	logic [15:0] cfg_wdata;

	link_tracker sb;
	logic [31:0] t_now;
	bit          cmd_calm;
	bit          rsp_calm;
	int          cycle_count;

	link_handshake_heartbeat_engine_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int draw_wait(bit calm);
		if (calm)
			return 0;
		case ($urandom_range(0, 3))
			0: return 0;
			1: return $urandom_range(1, 3);
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	function automatic cmd_t mk(op_t op, logic [31:0] tm, logic [7:0] len, logic [7:0] hdr,
		logic [7:0] opc, logic [31:0] seq);
		cmd_t c;
		c.operation    = op;
		c.time_now     = tm;
		c.dgram_length = len;
		c.header_byte  = hdr;
		c.opcode       = opc;
		c.rx_sequence  = seq;
		return c;
	endfunction

	function automatic logic [31:0] step_time();
		t_now = t_now + 32'($urandom_range(0, 40));
		return t_now;
	endfunction

	// Tick times land near the running deadlines often, so both sides of each
	// timeout boundary are hit; now and then time jumps anywhere.
	function automatic cmd_t tick_event();
		int pick;
		logic [31:0] base;
		logic [15:0] lim;
		pick = $urandom_range(0, 99);
		if (sb.st == LINK_HANDSHAKING) begin
			base = sb.hs_time;
			lim = sb.resp_to;
		end else if ($urandom_range(0, 1) == 0) begin
			base = sb.hb_tx_time;
			lim = sb.hb_int;
		end else begin
			base = sb.hb_rx_time;
			lim = sb.hb_to;
		end
		if (pick < 55)
			t_now = t_now + 32'($urandom_range(0, 300));
		else if (pick < 80)
			t_now = base + {16'd0, lim} + 32'($urandom_range(0, 1));
		else if (pick < 97)
			t_now = t_now + 32'($urandom_range(0, 70000));
		else
			t_now = $urandom();
		return mk(OP_TICK, t_now, 8'($urandom), 8'($urandom), 8'($urandom), $urandom());
	endfunction

	function automatic cmd_t app_event(logic [7:0] opc);
		return mk(OP_APP_SEND, step_time(), 8'($urandom), 8'($urandom), opc, $urandom());
	endfunction

	function automatic cmd_t lost_event();
		return mk(OP_LINK_LOST, step_time(), 8'($urandom), 8'($urandom), 8'($urandom),
			$urandom());
	endfunction

	function automatic cmd_t good_dgram(logic [7:0] opc);
		logic [31:0] seq;
		// A rare jump into the upper half of the sequence space, leaving room to grow.
		if ($urandom_range(0, 199) == 0 && sb.st == LINK_UP && sb.rx_seq_hi[31] == 1'b0)
			seq = {2'b10, 30'($urandom)};
		else
			seq = sb.rx_seq_hi + 32'($urandom_range(1, 4));
		return mk(OP_DATAGRAM, step_time(), 8'($urandom_range(MIN_DGRAM_LEN, 255)),
			sb.hdr_val, opc, seq);
	endfunction

	function automatic cmd_t bad_dgram(logic [7:0] opc);
		cmd_t c;
		c = good_dgram(opc);
		case ($urandom_range(0, 2))
			0: c.dgram_length = 8'($urandom_range(0, MIN_DGRAM_LEN - 1));
			1: c.header_byte = sb.hdr_val ^ 8'($urandom_range(1, 255));
			default: begin
				if (sb.rx_seq_hi >= 32'd2)
					c.rx_sequence = sb.rx_seq_hi - 32'($urandom_range(0, 2));
				else
					c.rx_sequence = sb.rx_seq_hi;
			end
		endcase
		return c;
	endfunction

	// Fully random datagram; the header is kept wrong so that noise never moves
	// the receive sequence out of reach of later handshakes.
	function automatic cmd_t noise_dgram();
		cmd_t c;
		c = mk(OP_DATAGRAM, step_time(), 8'($urandom), 8'($urandom), 8'($urandom), $urandom());
		if (c.header_byte == sb.hdr_val)
			c.header_byte = ~c.header_byte;
		return c;
	endfunction

	function automatic cmd_t next_event();
		int pick;
		pick = $urandom_range(0, 99);
		case (sb.st)
			LINK_DOWN: begin
				if (pick < 70) return tick_event();
				if (pick < 80) return app_event(8'($urandom));
				if (pick < 90) return good_dgram(OPC_HANDSHAKE2);
				if (pick < 95) return noise_dgram();
				return lost_event();
			end
			LINK_HANDSHAKING: begin
				if (pick < 45) return good_dgram(OPC_HANDSHAKE2);
				if (pick < 55) return good_dgram(8'($urandom));
				if (pick < 65) return bad_dgram(OPC_HANDSHAKE2);
				if (pick < 90) return tick_event();
				if (pick < 95) return app_event(8'($urandom));
				return lost_event();
			end
			default: begin
				if (pick < 25) return good_dgram(OPC_HEARTBEAT);
				if (pick < 35) return good_dgram(OPC_PING);
				if (pick < 50) return good_dgram(8'($urandom_range(NET_OPC_LIMIT, 255)));
				if (pick < 55) return good_dgram(8'($urandom_range(0, NET_OPC_LIMIT - 1)));
				if (pick < 63) return bad_dgram(8'($urandom));
				if (pick < 66) return noise_dgram();
				if (pick < 75) return app_event(8'($urandom));
				if (pick < 98) return tick_event();
				return lost_event();
			end
		endcase
	endfunction

	task automatic send_cmd(input cmd_t item);
		int gap;
		gap = draw_wait(cmd_calm);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= item;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		sb.note_event(item);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.note_cfg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : rsp_side
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rsp_calm = !rsp_calm;
			hold = draw_wait(rsp_calm);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			sb.check_result(rsp);
		end
	end

	initial begin : stimulus
		logic [31:0] b;
		logic [15:0] v_rt, v_rl, v_hi, v_ht, v_hv;
		cmd_t nxt;
		int counted;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		rsp_stall = 1'b1;
		cfg_we = 1'b0;
		cfg_index = REG_RESPONSE_TIMEOUT;
		cfg_wdata = 16'd0;
		cmd_calm = 1'b0;
		rsp_calm = 1'b0;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass on the reset settings; times start just below the wrap so
		// the retry timers straddle it.
		b = 32'hFFFF_FC00;
		// A datagram while disconnected is ignored.
		send_cmd(mk(OP_DATAGRAM, b, 8'd20, 8'd0, OPC_HANDSHAKE2, 32'd5));
		send_cmd(mk(OP_APP_SEND, b, 8'($urandom), 8'($urandom), 8'hFF, $urandom()));
		send_cmd(mk(OP_TICK, b, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
		// Exactly on the deadline nothing happens; one past it retries.
		send_cmd(mk(OP_TICK, b + 1000, 8'd0, 8'd0, 8'd0, 32'd0));
		send_cmd(mk(OP_TICK, b + 1001, 8'($urandom), 8'($urandom), 8'($urandom), $urandom()));
		send_cmd(mk(OP_DATAGRAM, b + 1002, 8'd7, 8'd0, OPC_HANDSHAKE2, 32'd1));
		send_cmd(mk(OP_DATAGRAM, b + 1003, 8'd8, 8'hFF, OPC_HANDSHAKE2, 32'd1));
		send_cmd(mk(OP_DATAGRAM, b + 1004, 8'd8, 8'd0, OPC_HANDSHAKE2, 32'd0));
		send_cmd(mk(OP_TICK, b + 2002, 8'($urandom), 8'($urandom), 8'($urandom), $urandom()));
		// Retries are used up: the handshake gives up.
		send_cmd(mk(OP_TICK, b + 3003, 8'($urandom), 8'($urandom), 8'($urandom), $urandom()));
		send_cmd(mk(OP_TICK, b + 3004, 8'($urandom), 8'($urandom), 8'($urandom), $urandom()));
		// Any reply but the second handshake is a wrong response.
		send_cmd(mk(OP_DATAGRAM, b + 3005, 8'd8, 8'd0, OPC_HEARTBEAT, 32'd1));
		send_cmd(mk(OP_TICK, b + 3006, 8'($urandom), 8'($urandom), 8'($urandom), $urandom()));
		send_cmd(mk(OP_DATAGRAM, b + 3007, 8'd255, 8'd0, OPC_HANDSHAKE2, 32'd2));
		send_cmd(mk(OP_DATAGRAM, b + 3008, 8'd8, 8'd0, OPC_PING, 32'd3));
		send_cmd(mk(OP_DATAGRAM, b + 3009, 8'd9, 8'd0, 8'hFF, 32'd4));
		send_cmd(mk(OP_DATAGRAM, b + 3010, 8'd8, 8'd0, NET_OPC_LIMIT, 32'd5));
		send_cmd(mk(OP_DATAGRAM, b + 3011, 8'd8, 8'd0, 8'h0F, 32'd6));
		send_cmd(mk(OP_DATAGRAM, b + 4000, 8'd8, 8'd0, OPC_HEARTBEAT, 32'd8));
		send_cmd(mk(OP_TICK, b + 4008, 8'($urandom), 8'($urandom), 8'($urandom), $urandom()));
		// Heartbeat sent and heartbeat timeout in the same tick: two results.
		send_cmd(mk(OP_TICK, b + 9001, 8'($urandom), 8'($urandom), 8'($urandom), $urandom()));
		send_cmd(mk(OP_LINK_LOST, b + 9002, 8'd0, 8'd0, 8'd0, 32'd0));
		send_cmd(mk(OP_TICK, b + 9003, 8'($urandom), 8'($urandom), 8'($urandom), $urandom()));
		send_cmd(mk(OP_LINK_LOST, b + 9004, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
		send_cmd(mk(OP_APP_SEND, b + 9005, 8'($urandom), 8'($urandom), 8'h00, $urandom()));
		t_now = b + 9010;
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					v_rt = 16'($urandom_range(0, 50));
					v_rl = 16'($urandom_range(1, 15));
					v_hi = 16'($urandom_range(0, 50));
					v_ht = 16'($urandom_range(50, 400));
					v_hv = 16'($urandom_range(0, 255));
				end
				1: begin
					v_rt = 16'hFFFF;
					v_rl = 16'h000F;
					v_hi = 16'hFFFF;
					v_ht = 16'hFFFF;
					v_hv = 16'h00FF;
				end
				2: begin
					v_rt = 16'h0000;
					v_rl = 16'h0000;
					v_hi = 16'h0000;
					v_ht = 16'h0000;
					v_hv = 16'h0000;
				end
				3: begin
					// Unused upper bits of the narrow registers carry junk.
					v_rt = 16'($urandom);
					v_rl = 16'($urandom);
					v_hi = 16'($urandom);
					v_ht = 16'($urandom);
					v_hv = 16'($urandom);
				end
				4: begin
					v_rt = 16'($urandom_range(100, 2000));
					v_rl = 16'h0001;
					v_hi = 16'($urandom_range(100, 1000));
					v_ht = 16'($urandom_range(1000, 5000));
					v_hv = 16'($urandom_range(0, 255));
				end
				default: begin
					v_rt = 16'($urandom_range(0, 3000));
					v_rl = {12'($urandom), 4'($urandom_range(1, 15))};
					v_hi = 16'($urandom_range(0, 2000));
					v_ht = 16'($urandom_range(0, 8000));
					v_hv = 16'($urandom);
				end
			endcase
			write_reg(REG_RESPONSE_TIMEOUT, v_rt);
			write_reg(REG_RETRY_LIMIT, v_rl);
			write_reg(REG_HEARTBEAT_INTERVAL, v_hi);
			write_reg(REG_HEARTBEAT_TIMEOUT, v_ht);
			write_reg(REG_HEADER_VALUE, v_hv);
			counted = 0;
			while (counted < 96) begin
				if ($urandom_range(0, 49) == 0)
					cmd_calm = !cmd_calm;
				nxt = next_event();
				if (!(nxt.operation == OP_DATAGRAM && sb.st == LINK_DOWN))
					counted++;
				send_cmd(nxt);
				if ($urandom_range(0, 119) == 0)
					drain();
			end
			drain();
		end

		cmd_valid <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.due_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
